// File: rtl/cse_pkg.sv
// Shared types and constants for the CAN signal extract and scale block.
// No dependencies; every rtl file refers to this package by scoped names.
package cse_pkg;

    // Configuration register indexes on the write port.
    localparam logic [2:0] REG_SIG_START     = 3'd0;
    localparam logic [2:0] REG_SIG_LENGTH    = 3'd1;
    localparam logic [2:0] REG_INTEL_ORDER   = 3'd2;
    localparam logic [2:0] REG_SIGNED_SIGNAL = 3'd3;
    localparam logic [2:0] REG_SCALE_FACTOR  = 3'd4;
    localparam logic [2:0] REG_SCALE_OFFSET  = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    // Byte position as seen by the bit mapper (covers up to 64 bytes).
    localparam int POS_W     = 7;
    // Signed frame bit index, wide enough for byte 64 minus start bit 511.
    localparam int BIT_IDX_W = 12;
    // Longest signal in bits.
    localparam int SIG_MAX   = 64;

    localparam logic signed [63:0] PHYS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] PHYS_MIN = 64'sh8000_0000_0000_0000;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [8:0]         sig_start;
        logic [6:0]         sig_length;
        logic               intel_order;
        logic               signed_signal;
        logic signed [31:0] scale_factor;
        logic signed [47:0] scale_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sig_start:     9'd0,
        sig_length:    7'd8,
        intel_order:   1'b1,
        signed_signal: 1'b0,
        scale_factor:  32'sd65536,
        scale_offset:  48'sd0
    };

endpackage

// File: rtl/cse_bit_map.sv
// Bit mapper: places the signal bits of one payload byte into a 64-bit mask.
// Handles Intel and Motorola sawtooth layouts; depends on cse_pkg.
module cse_bit_map (
    input  cse_pkg::cfg_t   cfg,
    input  cse_pkg::pos_t   pos,
    input  logic [7:0]      byte_val,
    output logic [63:0]     mask
);

    logic signed [cse_pkg::BIT_IDX_W-1:0] frame_bit;
    logic signed [cse_pkg::BIT_IDX_W-1:0] start_s;
    logic signed [cse_pkg::BIT_IDX_W-1:0] moto_start;
    logic signed [cse_pkg::BIT_IDX_W-1:0] len_s;
    logic signed [cse_pkg::BIT_IDX_W-1:0] idx   [8];
    logic signed [cse_pkg::BIT_IDX_W-1:0] dest  [8];
    logic                                 hit   [8];
    logic                                 len_ok;

    assign frame_bit  = cse_pkg::BIT_IDX_W'({pos, 3'b000});
    assign start_s    = cse_pkg::BIT_IDX_W'(cfg.sig_start);
    // Motorola start measured in MSB-first numbering.
    assign moto_start = cse_pkg::BIT_IDX_W'({cfg.sig_start[8:3], 3'b111})
                      - cse_pkg::BIT_IDX_W'(cfg.sig_start[2:0]);
    assign len_s      = cse_pkg::BIT_IDX_W'(cfg.sig_length);
    assign len_ok     = (cfg.sig_length != 7'd0)
                     && (cfg.sig_length <= 7'(cse_pkg::SIG_MAX));

    always_comb begin
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (cfg.intel_order) begin
                idx[b]  = frame_bit + cse_pkg::BIT_IDX_W'(b) - start_s;
                dest[b] = idx[b];
            end else begin
                idx[b]  = frame_bit + cse_pkg::BIT_IDX_W'(7 - b) - moto_start;
                dest[b] = len_s - cse_pkg::BIT_IDX_W'(1) - idx[b];
            end
            hit[b] = byte_val[b] && len_ok && (idx[b] >= 0) && (idx[b] < len_s);
            if (hit[b]) begin
                mask[dest[b][5:0]] = 1'b1;
            end
        end
    end

endmodule

// File: rtl/cse_scale.sv
// Scaling pipeline: signed raw times Q16.16 factor plus Q32.16 offset, saturated.
// Two stages: split partial products, then sum and clip. Depends on cse_pkg.
module cse_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  cse_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         in_raw,
    input  logic [63:0]         in_sraw,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_raw,
    output logic signed [63:0]  out_sraw,
    output logic signed [63:0]  out_phys,
    output logic                out_sat
);

    logic                a_valid_reg, a_valid_next;
    logic signed [64:0]  p_lo_reg, p_lo_next;
    logic signed [64:0]  p_hi_reg, p_hi_next;
    logic [63:0]         a_raw_reg;
    logic [63:0]         a_sraw_reg;
    logic                a_move;

    logic                b_valid_reg, b_valid_next;
    logic [63:0]         b_raw_reg;
    logic signed [63:0]  b_sraw_reg;
    logic signed [63:0]  b_phys_reg, b_phys_next;
    logic                b_sat_reg, b_sat_next;

    logic [64:0]         base;
    logic signed [97:0]  sum;
    logic                fits;

    assign a_move   = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_move;

    // Base is 65-bit signed: sign bit only when the signal is two's complement.
    assign base = {cfg.signed_signal & in_sraw[63], in_sraw};

    always_comb begin
        p_lo_next    = $signed({1'b0, base[31:0]}) * cfg.scale_factor;
        p_hi_next    = $signed(base[64:32]) * cfg.scale_factor;
        a_valid_next = (in_valid && in_ready) ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
        if (in_valid && in_ready) begin
            p_lo_reg   <= p_lo_next;
            p_hi_reg   <= p_hi_next;
            a_raw_reg  <= in_raw;
            a_sraw_reg <= in_sraw;
        end
    end

    // Recombine partial products, add offset, clip to 64 bits.
    always_comb begin
        sum = $signed({{1{p_hi_reg[64]}}, p_hi_reg, 32'b0})
            + 98'(p_lo_reg)
            + 98'(cfg.scale_offset);
        fits = (&sum[97:63]) || !(|sum[97:63]);
        if (fits) begin
            b_phys_next = sum[63:0];
            b_sat_next  = 1'b0;
        end else begin
            b_phys_next = sum[97] ? cse_pkg::PHYS_MIN : cse_pkg::PHYS_MAX;
            b_sat_next  = 1'b1;
        end
        b_valid_next = a_move ? 1'b1 : (out_ready ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
        if (a_move) begin
            b_raw_reg  <= a_raw_reg;
            b_sraw_reg <= a_sraw_reg;
            b_phys_reg <= b_phys_next;
            b_sat_reg  <= b_sat_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_raw   = b_raw_reg;
    assign out_sraw  = b_sraw_reg;
    assign out_phys  = b_phys_reg;
    assign out_sat   = b_sat_reg;

endmodule

// File: rtl/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
// Instantiates cse_bit_map and cse_scale; uses types and constants of cse_pkg.
//
// Usage:
//   Input channel (s_): one payload beat per byte, byte 0 first; s_final_byte
//   marks the last byte of a frame. Bytes past MAX_FRAME_BYTES are dropped but
//   a final mark on them still closes the frame.
//   Result channel (m_): one beat per frame, issued for the final byte: raw
//   bits, sign-extended raw, Q48.16 physical value and a saturation flag.
//   Config port (cfg_): write-only, one register per cycle at cfg_we; write
//   only while no frame is in flight and no result is pending.
// Throughput: one byte per cycle, back to back across frames, while results drain.
// Path: a final byte passes the input register, the bit gather, the partial
//   products and the sum and clip before m_valid rises.
// The depth is set by the 65x32 multiply, split into two 33x32 products,
//   and the 98-bit sum that follows it.
// Reset: synchronous, active low; clears the pipeline, the accumulator and
//   the byte counter, and loads the register defaults (start 0, length 8,
//   Intel order, unsigned, factor 1.0, offset 0).
// Stall: with m_ready low the result holds; the upper stages still fill, and
//   s_ready drops only once every stage holds a beat.
module can_signal_extract_scale #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [cse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cse_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_payload_byte,
    input  logic                              s_final_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [63:0]                       m_raw_value,
    output logic signed [63:0]                m_signed_raw,
    output logic signed [63:0]                m_physical_value,
    output logic                              m_saturated
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // Configuration registers.
    cse_pkg::cfg_t      cfg_reg, cfg_next;

    // Byte counter in front of the input register.
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               pos_live;

    // Input register.
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_final_reg;
    logic               in_live_reg;
    logic [CNT_W-1:0]   in_pos_reg;
    logic               in_consume;
    logic               s_accept;

    // Gather stage.
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        byte_mask;
    logic [63:0]        gathered;
    logic               len_ok;
    logic               sext_en;
    logic [63:0]        raw_next;
    logic [63:0]        sraw_next;
    logic               raw_valid_reg, raw_valid_next;
    logic [63:0]        raw_reg;
    logic [63:0]        sraw_reg;
    logic               scale_ready;
    logic               frame_done;

    // ---------------------------------------------------------------
    // Configuration write port
    // ---------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                cse_pkg::REG_SIG_START:     cfg_next.sig_start     = cfg_data[8:0];
                cse_pkg::REG_SIG_LENGTH:    cfg_next.sig_length    = cfg_data[6:0];
                cse_pkg::REG_INTEL_ORDER:   cfg_next.intel_order   = cfg_data[0];
                cse_pkg::REG_SIGNED_SIGNAL: cfg_next.signed_signal = cfg_data[0];
                cse_pkg::REG_SCALE_FACTOR:  cfg_next.scale_factor  = $signed(cfg_data[31:0]);
                cse_pkg::REG_SCALE_OFFSET:  cfg_next.scale_offset  = $signed(cfg_data[47:0]);
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= cse_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Input register and byte counter
    // ---------------------------------------------------------------
    // An input beat leaves the register at once unless it closes a frame
    // and the gather register still holds an untaken frame.
    assign in_consume = in_valid_reg
                     && (!in_final_reg || !raw_valid_reg || scale_ready);
    assign s_ready    = !in_valid_reg || in_consume;
    assign s_accept   = s_valid && s_ready;

    // Count bytes up to the limit; hold there so later bytes are dropped.
    assign pos_live = (pos_reg < CNT_W'(MAX_FRAME_BYTES));

    always_comb begin
        pos_next = pos_reg;
        if (s_accept) begin
            if (s_final_byte) begin
                pos_next = '0;
            end else if (pos_live) begin
                pos_next = pos_reg + CNT_W'(1);
            end
        end
        in_valid_next = s_accept ? 1'b1 : (in_consume ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            in_valid_reg <= in_valid_next;
        end
        if (s_accept) begin
            in_byte_reg  <= s_payload_byte;
            in_final_reg <= s_final_byte;
            in_live_reg  <= pos_live;
            in_pos_reg   <= pos_reg;
        end
    end

    // ---------------------------------------------------------------
    // Bit gather into the accumulator
    // ---------------------------------------------------------------
    cse_bit_map u_bit_map (
        .cfg      (cfg_reg),
        .pos      (cse_pkg::pos_t'(in_pos_reg)),
        .byte_val (in_live_reg ? in_byte_reg : 8'h00),
        .mask     (byte_mask)
    );

    assign gathered   = acc_reg | byte_mask;
    assign frame_done = in_consume && in_final_reg;

    // Length outside 1..64 yields zero; signed signals shorter than 64 are sign-extended.
    assign len_ok  = (cfg_reg.sig_length != 7'd0)
                  && (cfg_reg.sig_length <= 7'(cse_pkg::SIG_MAX));
    assign sext_en = cfg_reg.signed_signal && len_ok
                  && (cfg_reg.sig_length != 7'(cse_pkg::SIG_MAX));

    always_comb begin
        raw_next  = len_ok ? gathered : 64'd0;
        sraw_next = raw_next;
        if (sext_en && raw_next[6'(cfg_reg.sig_length - 7'd1)]) begin
            sraw_next = raw_next | ({64{1'b1}} << cfg_reg.sig_length);
        end
        acc_next = acc_reg;
        if (in_consume) begin
            acc_next = in_final_reg ? 64'd0 : gathered;
        end
        raw_valid_next = frame_done ? 1'b1 : (scale_ready ? 1'b0 : raw_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            raw_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            raw_valid_reg <= raw_valid_next;
        end
        if (frame_done) begin
            raw_reg  <= raw_next;
            sraw_reg <= sraw_next;
        end
    end

    // ---------------------------------------------------------------
    // Scaling pipeline and result register
    // ---------------------------------------------------------------
    cse_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (raw_valid_reg),
        .in_ready  (scale_ready),
        .in_raw    (raw_reg),
        .in_sraw   (sraw_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_raw   (m_raw_value),
        .out_sraw  (m_signed_raw),
        .out_phys  (m_physical_value),
        .out_sat   (m_saturated)
    );

`ifndef NO_ASSERTIONS
    // The byte counter never runs past the frame limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= CNT_W'(MAX_FRAME_BYTES))
        else $error("byte counter past frame limit");

    // Closing a frame leaves a clean accumulator for the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (acc_reg == 64'd0))
        else $error("accumulator not cleared after final byte");

    // A clipped result sits exactly on one of the int64 limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_physical_value == cse_pkg::PHYS_MAX)
            || (m_physical_value == cse_pkg::PHYS_MIN))
        else $error("saturated result off the limits");

    // A final byte never leaves the input register while the gather stage
    // holds a frame the scaler cannot take.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (raw_valid_reg && !scale_ready) |-> !frame_done)
        else $error("frame overwritten in gather stage");
`endif

endmodule

// File: test/signal_decode_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the CAN signal extract and scale block: bit gathering, scaling and
// result checking. Depends on cse_pkg for the register indexes and the config type.
package signal_decode_check_pkg;
    import cse_pkg::*;

    localparam int FRAME_BYTES  = 64;
    localparam int SIG_BITS     = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [63:0] raw;
        logic [63:0] sraw;
        logic [63:0] phys;
        logic        sat;
    } decoded_t;

    class signal_decode_scoreboard;
        cfg_t        regs;
        logic [63:0] gathered;
        int          bytes_seen;
        decoded_t    pending_decodes[$];
        int unsigned mismatches;

        function new();
            regs.sig_start     = 9'd0;
            regs.sig_length    = 7'd8;
            regs.intel_order   = 1'b1;
            regs.signed_signal = 1'b0;
            regs.scale_factor  = 32'sd65536;
            regs.scale_offset  = 48'sd0;
            gathered           = '0;
            bytes_seen         = 0;
            mismatches         = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_SIG_START:     regs.sig_start     = value[8:0];
                REG_SIG_LENGTH:    regs.sig_length    = value[6:0];
                REG_INTEL_ORDER:   regs.intel_order   = value[0];
                REG_SIGNED_SIGNAL: regs.signed_signal = value[0];
                REG_SCALE_FACTOR:  regs.scale_factor  = value[31:0];
                REG_SCALE_OFFSET:  regs.scale_offset  = value[47:0];
                default: ;
            endcase
        endfunction

        // Fold one accepted payload beat into the signal; on the final beat
        // queue the expected raw, signed and physical values.
        function void note_byte(logic [7:0] data, logic last);
            int                  len, start, first, idx;
            logic [63:0]         raw, sraw;
            logic signed [127:0] base, gain, bias, total;
            decoded_t            want;
            len   = regs.sig_length;
            start = regs.sig_start;
            // Motorola: position of the signal MSB when each byte counts from bit 7 down
            first = (start / 8) * 8 + 7 - start % 8;
            if (bytes_seen < FRAME_BYTES) begin
                if (len >= 1 && len <= SIG_BITS) begin
                    for (int k = 0; k < 8; k++) begin
                        if (data[k]) begin
                            if (regs.intel_order) begin
                                idx = bytes_seen * 8 + k - start;
                                if (idx >= 0 && idx < len) gathered[idx] = 1'b1;
                            end else begin
                                idx = bytes_seen * 8 + 7 - k - first;
                                if (idx >= 0 && idx < len) gathered[len - 1 - idx] = 1'b1;
                            end
                        end
                    end
                end
                bytes_seen++;
            end
            if (!last) return;

            raw  = (len >= 1 && len <= SIG_BITS) ? gathered : 64'd0;
            sraw = raw;
            if (regs.signed_signal && len >= 1 && len < SIG_BITS && raw[len - 1])
                sraw = raw | ~((64'd1 << len) - 64'd1);
            base  = regs.signed_signal ? {{64{sraw[63]}}, sraw} : {64'd0, raw};
            gain  = {{96{regs.scale_factor[31]}}, regs.scale_factor};
            bias  = {{80{regs.scale_offset[47]}}, regs.scale_offset};
            total = base * gain + bias;

            want.raw  = raw;
            want.sraw = sraw;
            if (total[127:63] == {65{total[63]}}) begin
                want.phys = total[63:0];
                want.sat  = 1'b0;
            end else begin
                want.phys = total[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                want.sat  = 1'b1;
            end
            pending_decodes.push_back(want);
            gathered   = '0;
            bytes_seen = 0;
        endfunction

        function void check_result(decoded_t got);
            decoded_t want;
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat with nothing pending: raw %h phys %h",
                             got.raw, got.phys);
                return;
            end
            want = pending_decodes.pop_front();
            if (got.raw !== want.raw || got.sraw !== want.sraw ||
                got.phys !== want.phys || got.sat !== want.sat) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("decode mismatch at %0t", $realtime);
                    $display("  raw        exp %h got %h", want.raw, got.raw);
                    $display("  signed_raw exp %h got %h", want.sraw, got.sraw);
                    $display("  physical   exp %h got %h", want.phys, got.phys);
                    $display("  saturated  exp %b got %b", want.sat, got.sat);
                end
            end
        endfunction
    endclass

endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for can_signal_extract_scale: drives payload beats and register
// writes, throttles the result side, checks every result. Needs cse_pkg and the check pkg.
module testbench;
    import cse_pkg::*;
    import signal_decode_check_pkg::*;

    localparam int SETTLE_CYCLES = 10;     // settle time after the pipeline has emptied
    localparam int CHOKE_CYCLES  = 300;    // long result-side hold to back the block up
    localparam int RANDOM_ITEMS  = 900;
    localparam int CALM_ITEMS    = 140;    // tail of the run with no idling at all
    localparam int CYCLE_LIMIT   = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_payload_byte;
    logic                  s_final_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [63:0]           m_raw_value;
    logic signed [63:0]    m_signed_raw;
    logic signed [63:0]    m_physical_value;
    logic                  m_saturated;

    signal_decode_scoreboard board;
    bit                      choke_rx;      // ask the result side for one long hold
    bit                      quiet_tail;    // stop all idling on both sides
    int                      items_sent;

    can_signal_extract_scale u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hand one payload beat to the block. Maybe idle first for a random burst,
    // then raise valid and hold it, payload steady, until the beat is taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= data;
        s_final_byte   <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        board.note_byte(data, last);
    endtask

    // Send a whole frame of random bytes; the last one carries the final mark.
    // Bytes past the frame limit are dropped by the block and are not counted.
    task automatic send_frame(input int nbytes);
        logic [7:0] data;
        for (int i = 0; i < nbytes; i++) begin
            case ($urandom_range(0, 7))
                0:       data = 8'h00;
                1:       data = 8'hFF;
                default: data = 8'($urandom);
            endcase
            send_byte(data, i == nbytes - 1);
            if (i < FRAME_BYTES || i == nbytes - 1) items_sent++;
        end
    endtask

    // Drop valid, wait for every pending result, then let the pipe go quiet.
    task automatic drain();
        @(negedge aclk);
        s_valid      <= 1'b0;
        s_final_byte <= 1'b0;
        while (board.pending_decodes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One-cycle register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_addr <= index;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        board.set_reg(index, value);
    endtask

    task automatic apply_settings(input logic [8:0] start, input logic [6:0] len,
                                  input logic intel, input logic sgn,
                                  input logic [31:0] factor, input logic [47:0] offset);
        write_reg(REG_SIG_START,     48'(start));
        write_reg(REG_SIG_LENGTH,    48'(len));
        write_reg(REG_INTEL_ORDER,   48'(intel));
        write_reg(REG_SIGNED_SIGNAL, 48'(sgn));
        write_reg(REG_SCALE_FACTOR,  48'(factor));
        write_reg(REG_SCALE_OFFSET,  offset);
    endtask

    // Random register set, weighted toward the extremes and toward start bits
    // that land inside the first few bytes so that frames actually cover them.
    task automatic pick_settings();
        logic [8:0]  start;
        logic [6:0]  len;
        logic [31:0] factor;
        logic [47:0] offset;
        case ($urandom_range(0, 3))
            0:       start = 9'($urandom_range(0, 511));
            1:       start = $urandom_range(0, 1) ? 9'd511 : 9'd0;
            default: start = 9'($urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 9))
            0:       len = 7'd64;
            1:       len = 7'd1;
            2:       len = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
            default: len = 7'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 5))
            0:       factor = 32'h7FFF_FFFF;
            1:       factor = 32'h8000_0000;
            2:       factor = 32'h0001_0000;
            3:       factor = 32'hFFFF_0000;
            default: factor = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       offset = 48'h7FFF_FFFF_FFFF;
            1:       offset = 48'h8000_0000_0000;
            2:       offset = 48'd0;
            default: offset = 48'({$urandom, $urandom});
        endcase
        apply_settings(start, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       factor, offset);
    endtask

    // Result side: ready changes on the falling edge, one assignment per edge.
    // Idle in random bursts, or hold off for a long stretch when asked.
    initial begin : result_sink
        int unsigned hold;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (choke_rx) begin
                choke_rx = 1'b0;
                hold     = CHOKE_CYCLES;
            end else if (hold == 0 && !quiet_tail && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 15);
            end
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sample result beats at the rising edge and check them in order.
    always @(posedge aclk) begin : result_monitor
        decoded_t seen;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            seen.raw  = m_raw_value;
            seen.sraw = m_signed_raw;
            seen.phys = m_physical_value;
            seen.sat  = m_saturated;
            board.check_result(seen);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int r, len, start, first, nbytes;
        board          = new();
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_payload_byte = '0;
        s_final_byte   = 1'b0;
        choke_rx       = 1'b0;
        quiet_tail     = 1'b0;
        items_sent     = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: byte 0 as an unsigned 8-bit Intel signal, unit factor.
        // A one-byte frame, then a non-final beat ahead of the final one.
        send_byte(8'hA5, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b1);
        drain();

        // Full 64-bit unsigned signal of all ones, largest factor and offset:
        // the product overflows and the physical value clips high.
        apply_settings(9'd0, 7'd64, 1'b1, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // Motorola from bit 7, only byte 0 arrives: the sign bit alone is set,
        // the missing bytes read as zero, and the result clips low.
        apply_settings(9'd7, 7'd64, 1'b0, 1'b1, 32'h7FFF_FFFF, 48'h8000_0000_0000);
        send_byte(8'h80, 1'b1);
        drain();

        // 12-bit Motorola signal across a byte boundary, most negative factor.
        apply_settings(9'd7, 7'd12, 1'b0, 1'b1, 32'h8000_0000, 48'h8000_0000_0000);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b1);
        drain();

        // One-bit signed signal reads as minus one.
        apply_settings(9'd4, 7'd1, 1'b1, 1'b1, 32'h0000_0001, 48'd0);
        send_byte(8'h10, 1'b1);
        drain();

        // Zero length and a length above 64: raw reads zero, physical is the offset.
        apply_settings(9'd0, 7'd0, 1'b1, 1'b0, 32'h0001_0000, 48'd12345);
        send_byte(8'hFF, 1'b1);
        drain();
        apply_settings(9'd3, 7'd100, 1'b0, 1'b1, 32'h0001_0000, 48'hFFFF_FFFF_0000);
        send_byte(8'hFF, 1'b1);
        drain();

        // Signal starting at the last bit of a 64-byte frame, frame of two bytes:
        // nothing of it arrives.
        apply_settings(9'd511, 7'd64, 1'b1, 1'b0, 32'h0001_0000, 48'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        // Back-pressure: hold the result side off while short frames keep coming,
        // so every stage fills and s_ready drops. Then pause until all drain.
        pick_settings();
        choke_rx = 1'b1;
        repeat (24) send_frame(1);
        drain();

        // Random phases: fresh registers, a few frames, drain before the next write.
        // Two in five frames just cover a valid signal; one in twenty runs past the limit.
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) quiet_tail = 1'b1;
            pick_settings();
            repeat ($urandom_range(2, 6)) begin
                r     = $urandom_range(0, 19);
                len   = board.regs.sig_length;
                start = board.regs.sig_start;
                first = board.regs.intel_order ? start : (start / 8) * 8 + 7 - start % 8;
                if (r == 0) begin
                    nbytes = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8);
                end else if (r <= 4) begin
                    nbytes = $urandom_range(9, FRAME_BYTES);
                end else if (r <= 11 || len < 1 || len > SIG_BITS) begin
                    nbytes = $urandom_range(1, 8);
                end else begin
                    nbytes = (first + len - 1) / 8 + 1;
                    if (nbytes > FRAME_BYTES) nbytes = FRAME_BYTES;
                end
                send_frame(nbytes);
            end
            drain();
        end

        drain();
        if (board.mismatches == 0 && board.pending_decodes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/cse_pkg.sv
rtl/cse_bit_map.sv
rtl/cse_scale.sv
rtl/can_signal_extract_scale.sv
test/signal_decode_check_pkg.sv
test/testbench.sv
